@@ rtl/pchd_pkg.sv @@
// Shared types and constants for the pairwise column Hamming distance unit.
// No dependencies; imported by the lane, merge and top-level modules.
`timescale 1ns / 1ps

package pchd_pkg;

    // Column word and result field widths
    localparam int COL_W   = 64;
    localparam int IDX_W   = 6;
    localparam int SEEN_W  = 7;
    localparam int DIST_W  = 7;

    // Default matrix size
    localparam int MAX_NODES_DEFAULT = 64;

    // Bit-slice lanes: each lane counts the differing rows of one slice
    localparam int LANES      = 4;
    localparam int LANE_W     = COL_W / LANES;
    localparam int LANE_CNT_W = $clog2(LANE_W + 1);

    typedef logic [LANES-1:0][LANE_CNT_W-1:0] lane_cnts_t;

    // Tag that travels with each comparison down the pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] new_idx;
        logic [IDX_W-1:0] old_idx;
        logic             last;
    } pchd_tag_t;

endpackage

@@ rtl/pchd_store.sv @@
// Column store: one write port, one read port with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module pchd_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write the arriving column, read one stored column per cycle while read is enabled
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/pchd_lane.sv @@
// One bit-slice lane: registered count of differing bits in its slice.
// Depends on pchd_pkg for the slice and count widths.
`timescale 1ns / 1ps

module pchd_lane (
    input  logic                            clk,
    input  logic                            en,
    input  logic [pchd_pkg::LANE_W-1:0]     a,
    input  logic [pchd_pkg::LANE_W-1:0]     b,
    output logic [pchd_pkg::LANE_CNT_W-1:0] count
);

    import pchd_pkg::*;

    logic [LANE_W-1:0]     diff;
    logic [LANE_CNT_W-1:0] count_next;
    logic [LANE_CNT_W-1:0] count_reg;

    // Count the rows where the two slices differ
    always_comb
    begin
        diff       = a ^ b;
        count_next = '0;
        for (int i = 0; i < LANE_W; i++)
        begin
            count_next = count_next + LANE_CNT_W'(diff[i]);
        end
    end

    // Hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

@@ rtl/pchd_merge.sv @@
// Merge stage: adds the lane counts into the distance and holds the result word.
// Depends on pchd_pkg for the lane count vector and the pipeline tag.
`timescale 1ns / 1ps

module pchd_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  pchd_pkg::lane_cnts_t        counts,
    input  pchd_pkg::pchd_tag_t         tag_in,
    output logic [pchd_pkg::DIST_W-1:0] distance,
    output pchd_pkg::pchd_tag_t         tag_out
);

    import pchd_pkg::*;

    logic [DIST_W-1:0] sum_next;
    logic [DIST_W-1:0] distance_reg;
    pchd_tag_t         tag_reg;

    // Add the partial counts of all lanes
    always_comb
    begin
        sum_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            sum_next = sum_next + DIST_W'(counts[l]);
        end
    end

    // Advance the result word, hold while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            distance_reg <= sum_next;
        end
    end

    assign distance = distance_reg;
    assign tag_out  = tag_reg;

endmodule

@@ rtl/pairwise_column_hamming_distance_unit.sv @@
// Top level of the pairwise column Hamming distance unit.
// Depends on pchd_pkg, pchd_store, pchd_lane and pchd_merge.
`timescale 1ns / 1ps

// Columns of a binary matrix arrive one word at a time; each is stored and
// compared with every earlier column of the same matrix, giving one distance
// word per earlier column in ascending order of its index, the last one
// flagged. A column with index k is taken, then issues its k comparisons at
// one per cycle while the output is not stalled, paced by the single read
// port of the column store; the read and lane stages of the three-stage
// read/lane/merge pipeline drain before the next column is taken. Rows at
// and above MAX_NODES are masked off, and a column that arrives without the
// first flag into a full matrix is dropped with no result. Output stalls
// hold the whole pipeline.

module pairwise_column_hamming_distance_unit #(
    parameter int MAX_NODES = pchd_pkg::MAX_NODES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        column_valid,
    output logic                        column_ready,
    input  logic [pchd_pkg::COL_W-1:0]  column_bits,
    input  logic                        first_column,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [pchd_pkg::IDX_W-1:0]  new_column_index,
    output logic [pchd_pkg::IDX_W-1:0]  earlier_column_index,
    output logic [pchd_pkg::DIST_W-1:0] distance,
    output logic                        last_of_run
);

    import pchd_pkg::*;

    localparam int                ADDR_W     = $clog2(MAX_NODES);
    localparam logic [COL_W-1:0]  ROW_MASK   = {COL_W{1'b1}} >> (COL_W - MAX_NODES);
    localparam logic [SEEN_W-1:0] NODE_LIMIT = SEEN_W'(MAX_NODES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    pchd_tag_t         s1_tag_reg, s1_tag_next;
    pchd_tag_t         s2_tag_reg;
    pchd_tag_t         out_tag;

    logic              accept;
    logic              adv;
    logic              run_last;
    logic [SEEN_W-1:0] idx_in;
    logic              wr_en;
    logic [COL_W-1:0]  rd_data;
    lane_cnts_t        lane_cnts;

    // Pipeline moves whenever the result register is free or being taken
    assign adv          = !out_tag.valid || result_ready;
    assign column_ready = (state_reg == ST_IDLE) && !s1_tag_reg.valid && !s2_tag_reg.valid;
    assign accept       = column_valid && column_ready;
    assign idx_in       = first_column ? '0 : seen_reg;
    assign wr_en        = accept && (idx_in < NODE_LIMIT);
    assign run_last     = (j_reg == idx_reg - IDX_W'(1));

    // Sequence: take a column, then issue one comparison per cycle while the output is not stalled
    always_comb
    begin
        state_next   = state_reg;
        seen_next    = seen_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        cur_col_next = cur_col_reg;
        s1_tag_next  = s1_tag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (adv)
                begin
                    s1_tag_next.valid = 1'b0;
                end
                if (wr_en)
                begin
                    cur_col_next = column_bits & ROW_MASK;
                    idx_next     = idx_in[IDX_W-1:0];
                    seen_next    = idx_in + SEEN_W'(1);
                    j_next       = '0;
                    if (idx_in != '0)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    s1_tag_next.valid   = 1'b1;
                    s1_tag_next.new_idx = idx_reg;
                    s1_tag_next.old_idx = j_reg;
                    s1_tag_next.last    = run_last;
                    j_next              = j_reg + IDX_W'(1);
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seen_reg   <= '0;
            idx_reg    <= '0;
            j_reg      <= '0;
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            seen_reg   <= seen_next;
            idx_reg    <= idx_next;
            j_reg      <= j_next;
            s1_tag_reg <= s1_tag_next;
            if (adv)
            begin
                s2_tag_reg <= s1_tag_reg;
            end
        end
    end

    // Hold the arriving column for the whole run
    always_ff @(posedge clk)
    begin
        cur_col_reg <= cur_col_next;
    end

    // Column store
    pchd_store #(
        .DEPTH  (MAX_NODES),
        .ADDR_W (ADDR_W),
        .DATA_W (COL_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_in[ADDR_W-1:0]),
        .wr_data (column_bits & ROW_MASK),
        .rd_en   (adv),
        .rd_addr (j_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Bit-slice lanes
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        pchd_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .a     (rd_data[l*LANE_W +: LANE_W]),
            .b     (cur_col_reg[l*LANE_W +: LANE_W]),
            .count (lane_cnts[l])
        );
    end

    // Combine lane counts into the result word
    pchd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .counts   (lane_cnts),
        .tag_in   (s2_tag_reg),
        .distance (distance),
        .tag_out  (out_tag)
    );

    assign result_valid         = out_tag.valid;
    assign new_column_index     = out_tag.new_idx;
    assign earlier_column_index = out_tag.old_idx;
    assign last_of_run          = out_tag.last;

endmodule
